/* src/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants and tables for the great-circle distance block
// Fixed-point constants (Q30 angles), coordinate limits and the CORDIC
// arctangent table used by both CORDIC pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    // Default number of CORDIC micro-rotations in both CORDIC pipelines.
    localparam int GCD_ITER_DEF = 24;

    // Coordinate limits in 2^-16 degree.
    localparam logic signed [25:0] LAT_MAX = 26'sd5898240;
    localparam logic signed [25:0] LON_MAX = 26'sd11796480;

    // Degrees (2^-16) to radians, scaled by 2^40, split for two partial products.
    localparam logic [34:0] RADQ40 = 35'd19190098069;
    localparam logic [16:0] RAD_LO = RADQ40[16:0];
    localparam logic [17:0] RAD_HI = RADQ40[34:17];

    // Angle constants in Q30 radians.
    localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [33:0] HALFPI_Q30 = 34'sd1686629713;

    // Unit and CORDIC start value (reciprocal of the CORDIC gain) in Q30.
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;

    // Sphere diameter in meters and the largest distance reported.
    localparam logic [23:0] DIAM_M   = 24'd12742000;
    localparam logic [24:0] DIST_MAX = 25'd20015087;

    // Square root input width (h << 30) and its digit count.
    localparam int SQRT_IN_W  = 61;
    localparam int SQRT_STEPS = (SQRT_IN_W + 1) / 2;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'd843314857;
            5'd1:  a = 32'd497837829;
            5'd2:  a = 32'd263043837;
            5'd3:  a = 32'd133525159;
            5'd4:  a = 32'd67021687;
            5'd5:  a = 32'd33543516;
            5'd6:  a = 32'd16775851;
            5'd7:  a = 32'd8388437;
            5'd8:  a = 32'd4194283;
            5'd9:  a = 32'd2097149;
            5'd10: a = 32'd1048576;
            5'd11: a = 32'd524288;
            5'd12: a = 32'd262144;
            5'd13: a = 32'd131072;
            5'd14: a = 32'd65536;
            5'd15: a = 32'd32768;
            5'd16: a = 32'd16384;
            5'd17: a = 32'd8192;
            5'd18: a = 32'd4096;
            5'd19: a = 32'd2048;
            5'd20: a = 32'd1024;
            5'd21: a = 32'd512;
            5'd22: a = 32'd256;
            5'd23: a = 32'd128;
            5'd24: a = 32'd64;
            5'd25: a = 32'd32;
            5'd26: a = 32'd16;
            5'd27: a = 32'd8;
            5'd28: a = 32'd4;
            5'd29: a = 32'd2;
            5'd30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* src/great_circle_distance.sv */
// ----------------------------------------------------------------------------
// great_circle_distance: haversine distance between two positions
//
// Input request (s_valid/s_ready): two positions, latitude and longitude in
// signed 2^-16 degree. Out-of-range coordinates are saturated. Result request
// (m_valid/m_ready): the great-circle distance on a 12742 km sphere in whole
// meters, rounded to nearest and capped at half the circumference.
// The datapath is one pipeline: input scaling, four rotation CORDICs for the
// sines and cosines, the haversine products, two digit-by-digit square roots
// and a vectoring CORDIC for the arcsine, then the scaling to meters.
// The pipeline has one register stage per CORDIC micro-rotation and per root bit.
// Throughput is one request per cycle while the receiver takes results, with
// results in input order.
// Reset clears every valid bit; the data registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = GCD_ITER_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [23:0] s_lat_a,
    input  wire logic signed [24:0] s_lon_a,
    input  wire logic signed [23:0] s_lat_b,
    input  wire logic signed [24:0] s_lon_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [24:0]             m_distance_m
);

    // Saturate a coordinate to +-lim.
    function automatic logic signed [25:0] sat26(input logic signed [25:0] v,
                                                 input logic signed [25:0] lim);
        logic signed [25:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    // Magnitude of a CORDIC output, limited to one.
    function automatic logic [30:0] clamp_mag(input logic signed [32:0] v);
        logic [32:0] a;
        a = v[32] ? 33'(-v) : 33'(v);
        return (a > 33'(ONE_Q30)) ? ONE_Q30 : a[30:0];
    endfunction

    // Drop 30 fraction bits of a Q60 product with rounding.
    function automatic logic [30:0] rnd30(input logic [61:0] p);
        logic [61:0] t;
        t = p + (62'd1 << 29);
        return t[60:30];
    endfunction

    logic pipe_en;
    logic m_valid_reg;
    logic [24:0] m_distance_m_reg;

    // The whole pipeline moves whenever the output register can take a result.
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // ---- Stage 1: saturate and form differences ----
    logic signed [25:0] la_s, oa_s, lb_s, ob_s;
    logic               v1_reg;
    logic signed [25:0] ang1_reg [0:3];

    assign la_s = sat26({{2{s_lat_a[23]}}, s_lat_a}, LAT_MAX);
    assign oa_s = sat26({s_lon_a[24], s_lon_a}, LON_MAX);
    assign lb_s = sat26({{2{s_lat_b[23]}}, s_lat_b}, LAT_MAX);
    assign ob_s = sat26({s_lon_b[24], s_lon_b}, LON_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
        end
    end

    // Angles in order: latitude difference, longitude difference, lat A, lat B.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ang1_reg[0] <= lb_s - la_s;
            ang1_reg[1] <= ob_s - oa_s;
            ang1_reg[2] <= la_s;
            ang1_reg[3] <= lb_s;
        end
    end

    // ---- Stage 2: partial products of the radian conversion ----
    localparam logic signed [18:0] RAD_HI_S = $signed({1'b0, RAD_HI});
    localparam logic signed [17:0] RAD_LO_S = $signed({1'b0, RAD_LO});

    logic               v2_reg;
    logic signed [44:0] phi2_reg [0:3];
    logic signed [43:0] plo2_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 4; k++) begin
                phi2_reg[k] <= ang1_reg[k] * RAD_HI_S;
                plo2_reg[k] <= ang1_reg[k] * RAD_LO_S;
            end
        end
    end

    // ---- Stage 3: combine, round and scale to Q30 radians ----
    // Differences are halved for the haversine, so they drop one more bit.
    logic signed [61:0] full3 [0:3];
    logic signed [61:0] shr3  [0:3];
    logic               v3_reg;
    logic signed [33:0] rad3_reg [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            full3[k] = $signed({phi2_reg[k], 17'b0}) +
                       $signed({{18{plo2_reg[k][43]}}, plo2_reg[k]});
            if (k < 2) begin
                shr3[k] = (full3[k] + (62'sd1 <<< 26)) >>> 27;
            end else begin
                shr3[k] = (full3[k] + (62'sd1 <<< 25)) >>> 26;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 4; k++) begin
                rad3_reg[k] <= shr3[k][33:0];
            end
        end
    end

    // ---- Stage 4: fold the longitude half-difference into +-pi/2 ----
    logic               v4_reg;
    logic signed [33:0] z4_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            z4_reg[0] <= rad3_reg[0];
            if (rad3_reg[1] > HALFPI_Q30) begin
                z4_reg[1] <= rad3_reg[1] - PI_Q30;
            end else if (rad3_reg[1] < -HALFPI_Q30) begin
                z4_reg[1] <= rad3_reg[1] + PI_Q30;
            end else begin
                z4_reg[1] <= rad3_reg[1];
            end
            z4_reg[2] <= rad3_reg[2];
            z4_reg[3] <= rad3_reg[3];
        end
    end

    // ---- Rotation CORDICs: sines of the half differences, cosines of lats ----
    logic               rot_valid;
    logic signed [32:0] rot_x [0:3];
    logic signed [32:0] rot_y [0:3];

    gcd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_dlat (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(v4_reg),
        .in_z(z4_reg[0]), .out_valid(rot_valid), .out_x(rot_x[0]), .out_y(rot_y[0])
    );

    gcd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_dlon (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(v4_reg),
        .in_z(z4_reg[1]), .out_valid(), .out_x(rot_x[1]), .out_y(rot_y[1])
    );

    gcd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_lata (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(v4_reg),
        .in_z(z4_reg[2]), .out_valid(), .out_x(rot_x[2]), .out_y(rot_y[2])
    );

    gcd_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_latb (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(v4_reg),
        .in_z(z4_reg[3]), .out_valid(), .out_x(rot_x[3]), .out_y(rot_y[3])
    );

    // ---- Clamp stage: magnitudes limited to one ----
    logic        vc_reg;
    logic [30:0] sx_reg, sy_reg, ca_reg, cb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (pipe_en) begin
            vc_reg <= rot_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sx_reg <= clamp_mag(rot_y[0]);
            sy_reg <= clamp_mag(rot_y[1]);
            ca_reg <= clamp_mag(rot_x[2]);
            cb_reg <= clamp_mag(rot_x[3]);
        end
    end

    // ---- Haversine products ----
    logic        vp1_reg, vp2_reg, vp3_reg, vp4_reg;
    logic [61:0] mxx1_reg, mcc1_reg, myy1_reg;
    logic [30:0] a2_reg, b2_reg, c2_reg;
    logic [30:0] a3_reg;
    logic [61:0] bc3_reg;
    logic [31:0] hsum4;
    logic [30:0] h4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
            vp3_reg <= 1'b0;
            vp4_reg <= 1'b0;
        end else if (pipe_en) begin
            vp1_reg <= vc_reg;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
            vp4_reg <= vp3_reg;
        end
    end

    assign hsum4 = {1'b0, a3_reg} + {1'b0, rnd30(bc3_reg)};

    // Squared sines and the cosine product, then their rounded combination.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mxx1_reg <= 62'(sx_reg) * 62'(sx_reg);
            mcc1_reg <= 62'(ca_reg) * 62'(cb_reg);
            myy1_reg <= 62'(sy_reg) * 62'(sy_reg);
            a2_reg   <= rnd30(mxx1_reg);
            b2_reg   <= rnd30(mcc1_reg);
            c2_reg   <= rnd30(myy1_reg);
            a3_reg   <= a2_reg;
            bc3_reg  <= 62'(b2_reg) * 62'(c2_reg);
            h4_reg   <= (hsum4 > 32'(ONE_Q30)) ? ONE_Q30 : hsum4[30:0];
        end
    end

    // ---- Square roots of h and 1 - h ----
    logic [30:0]           h_comp;
    logic                  sq_valid;
    logic [SQRT_STEPS-1:0] sq_root;
    logic [SQRT_STEPS-1:0] sq1_root;

    assign h_comp = ONE_Q30 - h4_reg;

    gcd_isqrt u_sqrt_h (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(vp4_reg),
        .in_v({h4_reg, 30'b0}), .out_valid(sq_valid), .out_root(sq_root)
    );

    gcd_isqrt u_sqrt_1mh (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(vp4_reg),
        .in_v({h_comp, 30'b0}), .out_valid(), .out_root(sq1_root)
    );

    // ---- Arcsine as atan2(sqrt(h), sqrt(1 - h)) ----
    logic        vec_valid;
    logic [31:0] vec_z;

    gcd_cordic_vec #(.ITER(CORDIC_ITERATIONS)) u_vec (
        .aclk(aclk), .aresetn(aresetn), .en(pipe_en), .in_valid(sq_valid),
        .in_y(sq_root[30:0]), .in_x(sq1_root[30:0]),
        .out_valid(vec_valid), .out_z(vec_z)
    );

    // ---- Scale to meters and register the result ----
    logic        vf1_reg;
    logic [55:0] dprod_reg;
    logic [55:0] dround;
    logic [25:0] dmeters;

    assign dround  = dprod_reg + (56'd1 << 29);
    assign dmeters = dround[55:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf1_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            vf1_reg     <= vec_valid;
            m_valid_reg <= vf1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dprod_reg        <= 56'(vec_z) * 56'(DIAM_M);
            m_distance_m_reg <= (dmeters > 26'(DIST_MAX)) ? DIST_MAX : dmeters[24:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_distance_m = m_distance_m_reg;

    // ---- Assertions ----
    // A reported distance never exceeds half the circumference.
    a_dist_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_distance_m <= DIST_MAX))
        else $error("distance above cap");

    // The input side stalls only while a result waits at the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without an output stall");

    // The haversine term reaching the square roots lies in [0, 1].
    a_h_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vp4_reg |-> (h4_reg <= ONE_Q30))
        else $error("haversine term out of range");

endmodule

`default_nettype wire

/* src/gcd_cordic_rot.sv */
// ----------------------------------------------------------------------------
// gcd_cordic_rot: pipelined rotation CORDIC
// One micro-rotation per register stage; gives cosine (x) and sine (y)
// of a Q30 angle, scaled to unit gain.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_cordic_rot
    import gcd_pkg::*;
#(
    parameter int ITER = GCD_ITER_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [33:0] in_z,
    output logic                    out_valid,
    output logic signed [32:0]      out_x,
    output logic signed [32:0]      out_y
);

    logic signed [32:0] x_reg [0:ITER-1];
    logic signed [32:0] y_reg [0:ITER-1];
    logic signed [33:0] z_reg [0:ITER-1];
    logic               v_reg [0:ITER-1];

    for (genvar k = 0; k < ITER; k++) begin : g_stage
        localparam logic signed [33:0] ANG = $signed({2'b00, atan_q30(5'(k))});
        logic signed [32:0] xi;
        logic signed [32:0] yi;
        logic signed [33:0] zi;
        logic               vi;

        // The first stage starts from the gain-corrected unit vector.
        if (k == 0) begin : g_first
            assign xi = INV_GAIN_Q30;
            assign yi = '0;
            assign zi = in_z;
            assign vi = in_valid;
        end else begin : g_next
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
            assign vi = v_reg[k-1];
        end

        // Valid bit of this stage.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= vi;
            end
        end

        // Turn toward zero residual angle.
        always_ff @(posedge aclk) begin
            if (en) begin
                if (zi >= 0) begin
                    x_reg[k] <= xi - (yi >>> k);
                    y_reg[k] <= yi + (xi >>> k);
                    z_reg[k] <= zi - ANG;
                end else begin
                    x_reg[k] <= xi + (yi >>> k);
                    y_reg[k] <= yi - (xi >>> k);
                    z_reg[k] <= zi + ANG;
                end
            end
        end
    end

    assign out_valid = v_reg[ITER-1];
    assign out_x     = x_reg[ITER-1];
    assign out_y     = y_reg[ITER-1];

endmodule

`default_nettype wire

/* src/gcd_isqrt.sv */
// ----------------------------------------------------------------------------
// gcd_isqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_isqrt
    import gcd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [SQRT_IN_W-1:0] in_v,
    output logic                      out_valid,
    output logic [SQRT_STEPS-1:0]     out_root
);

    localparam int W = SQRT_IN_W + 1;

    logic [W-1:0] rem_reg  [0:SQRT_STEPS-1];
    logic [W-1:0] root_reg [0:SQRT_STEPS-1];
    logic         v_reg    [0:SQRT_STEPS-1];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [W-1:0] remi;
        logic [W-1:0] rooti;
        logic [W-1:0] trial;
        logic         vi;

        if (j == 0) begin : g_first
            assign remi  = W'(in_v);
            assign rooti = '0;
            assign vi    = in_valid;
        end else begin : g_next
            assign remi  = rem_reg[j-1];
            assign rooti = root_reg[j-1];
            assign vi    = v_reg[j-1];
        end

        assign trial = rooti + BIT;

        // Valid bit of this step.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= vi;
            end
        end

        // Keep the trial bit when the remainder covers it.
        always_ff @(posedge aclk) begin
            if (en) begin
                if (remi >= trial) begin
                    rem_reg[j]  <= remi - trial;
                    root_reg[j] <= (rooti >> 1) + BIT;
                end else begin
                    rem_reg[j]  <= remi;
                    root_reg[j] <= rooti >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1][SQRT_STEPS-1:0];

endmodule

`default_nettype wire

/* src/gcd_cordic_vec.sv */
// ----------------------------------------------------------------------------
// gcd_cordic_vec: pipelined vectoring CORDIC
// One micro-rotation per register stage; gives atan2(y, x) in Q30 radians
// for a vector in the first quadrant, clamped at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_cordic_vec
    import gcd_pkg::*;
#(
    parameter int ITER = GCD_ITER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [30:0] in_y,
    input  wire logic [30:0] in_x,
    output logic             out_valid,
    output logic [31:0]      out_z
);

    logic signed [32:0] x_reg [0:ITER-1];
    logic signed [32:0] y_reg [0:ITER-1];
    logic signed [32:0] z_reg [0:ITER-1];
    logic               v_reg [0:ITER-1];

    for (genvar k = 0; k < ITER; k++) begin : g_stage
        localparam logic signed [32:0] ANG = $signed({1'b0, atan_q30(5'(k))});
        logic signed [32:0] xi;
        logic signed [32:0] yi;
        logic signed [32:0] zi;
        logic               vi;

        if (k == 0) begin : g_first
            assign xi = $signed({2'b00, in_x});
            assign yi = $signed({2'b00, in_y});
            assign zi = '0;
            assign vi = in_valid;
        end else begin : g_next
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
            assign vi = v_reg[k-1];
        end

        // Valid bit of this stage.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= vi;
            end
        end

        // Drive y toward zero and collect the angle turned.
        always_ff @(posedge aclk) begin
            if (en) begin
                if (yi > 0) begin
                    x_reg[k] <= xi + (yi >>> k);
                    y_reg[k] <= yi - (xi >>> k);
                    z_reg[k] <= zi + ANG;
                end else begin
                    x_reg[k] <= xi - (yi >>> k);
                    y_reg[k] <= yi + (xi >>> k);
                    z_reg[k] <= zi - ANG;
                end
            end
        end
    end

    assign out_valid = v_reg[ITER-1];
    assign out_z     = z_reg[ITER-1][32] ? 32'd0 : z_reg[ITER-1][31:0];

endmodule

`default_nettype wire
